/* src/source_text_tokenizer_defines.svh */
// assertion macros for the checker file
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// property checked outside reset
`define STT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define STT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/stt_pkg.sv */
package stt_pkg;

   // widths of positions, lengths and line numbers
   localparam int POS_BITS    = 16;
   localparam int OFF_BITS    = 16;
   localparam int LEN_BITS    = 16;
   localparam int LINE_BITS   = 16;
   localparam int KIND_BITS   = 5;
   localparam int CHAR_BITS   = 8;
   localparam int KW_CHARS    = 7;
   localparam int PREFIX_BITS = CHAR_BITS * KW_CHARS;

   // queue depths, powers of two so the pointers wrap by themselves
   localparam int ITEM_DEPTH    = 2;
   localparam int ITEM_PTR_BITS = $clog2(ITEM_DEPTH);
   localparam int ITEM_CNT_BITS = $clog2(ITEM_DEPTH + 1);
   localparam int OUT_DEPTH     = 4;
   localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

   // character codes
   localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_QUOTE   = 8'h22;
   localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_SEMI    = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CH_LBRACE  = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_RBRACE  = 8'h7D;

   // keywords, first letter in the low byte
   localparam logic [PREFIX_BITS-1:0] KW_PRINTLN = PREFIX_BITS'(64'h006E6C746E697270);
   localparam logic [PREFIX_BITS-1:0] KW_PRINT   = PREFIX_BITS'(64'h000000746E697270);
   localparam logic [PREFIX_BITS-1:0] KW_NUM     = PREFIX_BITS'(64'h00000000006D756E);
   localparam logic [PREFIX_BITS-1:0] KW_STRING  = PREFIX_BITS'(64'h0000676E69727473);
   localparam logic [PREFIX_BITS-1:0] KW_IF      = PREFIX_BITS'(64'h0000000000006669);
   localparam logic [LEN_BITS-1:0] KW_PRINTLN_LEN = LEN_BITS'(7);
   localparam logic [LEN_BITS-1:0] KW_PRINT_LEN   = LEN_BITS'(5);
   localparam logic [LEN_BITS-1:0] KW_NUM_LEN     = LEN_BITS'(3);
   localparam logic [LEN_BITS-1:0] KW_STRING_LEN  = LEN_BITS'(6);
   localparam logic [LEN_BITS-1:0] KW_IF_LEN      = LEN_BITS'(2);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PLUS        = 5'd0,
      KIND_MINUS       = 5'd1,
      KIND_MULT        = 5'd2,
      KIND_MOD         = 5'd3,
      KIND_LBRACE      = 5'd4,
      KIND_RBRACE      = 5'd5,
      KIND_SEMI        = 5'd6,
      KIND_EQ          = 5'd7,
      KIND_DIV         = 5'd8,
      KIND_EOF         = 5'd9,
      KIND_STRING      = 5'd10,
      KIND_PRINTLN     = 5'd11,
      KIND_PRINT       = 5'd12,
      KIND_NUM_DECL    = 5'd13,
      KIND_STRING_DECL = 5'd14,
      KIND_IF          = 5'd15,
      KIND_ID          = 5'd16,
      KIND_NUMBER      = 5'd17,
      KIND_ERROR       = 5'd18
   } kind_type;

   typedef enum logic [3:0] {
      CLS_BLANK,
      CLS_NEWLINE,
      CLS_OP,
      CLS_SLASH,
      CLS_QUOTE,
      CLS_END,
      CLS_LETTER,
      CLS_DIGIT,
      CLS_OTHER
   } class_type;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_SLASH   = 6'b000010,
      MODE_COMMENT = 6'b000100,
      MODE_STRING  = 6'b001000,
      MODE_WORD    = 6'b010000,
      MODE_NUMBER  = 6'b100000
   } mode_type;

   // classified byte, with position and line before the byte
   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      class_type            cls;
      kind_type             op_kind;
      logic [POS_BITS-1:0]  pos;
      logic [LINE_BITS-1:0] line;
   } item_type;

   typedef struct packed {
      kind_type             kind;
      logic [OFF_BITS-1:0]  offset;
      logic [LEN_BITS-1:0]  length;
      logic [LINE_BITS-1:0] line;
      logic                 last;
   } token_type;

   // up to two tokens from one byte
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } emit_type;

   // clamp a position to the offset field
   function automatic logic [OFF_BITS-1:0] pos_to_offset(input logic [POS_BITS-1:0] p);
      logic [POS_BITS+OFF_BITS-1:0] wide;
      logic [POS_BITS+OFF_BITS-1:0] limit;
      wide  = {{OFF_BITS{1'b0}}, p};
      limit = {{POS_BITS{1'b0}}, {OFF_BITS{1'b1}}};
      if (wide > limit) begin
         return '1;
      end
      return wide[OFF_BITS-1:0];
   endfunction

   // saturating position step
   function automatic logic [POS_BITS-1:0] pos_next(input logic [POS_BITS-1:0] p);
      return (p == '1) ? p : p + POS_BITS'(1);
   endfunction

endpackage

/* src/stt_front.sv */
module stt_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [stt_pkg::CHAR_BITS-1:0]          req_char_in,
   input  logic                                   push,
   output logic                                   full,
   output logic                                   item_valid,
   output stt_pkg::item_type                      item,
   input  logic                                   item_take
);
   import stt_pkg::*;

   logic [POS_BITS-1:0]      pos_ff, pos_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   item_type                 q_ff [ITEM_DEPTH];
   logic [ITEM_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ITEM_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ITEM_CNT_BITS-1:0] count_ff, count_in;
   logic                     accept;
   logic                     take_ok;
   item_type                 fresh;

   assign full       = (count_ff == ITEM_CNT_BITS'(ITEM_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take_ok    = item_take && item_valid;

   // byte classification
   always_comb begin
      fresh.ch      = req_char_in;
      fresh.pos     = pos_ff;
      fresh.line    = line_ff;
      fresh.op_kind = KIND_ERROR;
      case (req_char_in) inside
         CH_SPACE, CH_RETURN, CH_TAB: fresh.cls = CLS_BLANK;
         CH_NEWLINE:                  fresh.cls = CLS_NEWLINE;
         CH_NUL:                      fresh.cls = CLS_END;
         CH_SLASH:                    fresh.cls = CLS_SLASH;
         CH_QUOTE:                    fresh.cls = CLS_QUOTE;
         CH_PLUS: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_PLUS;
         end
         CH_MINUS: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_MINUS;
         end
         CH_STAR: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_MULT;
         end
         CH_PERCENT: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_MOD;
         end
         CH_LBRACE: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_LBRACE;
         end
         CH_RBRACE: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_RBRACE;
         end
         CH_SEMI: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_SEMI;
         end
         CH_EQUAL: begin
            fresh.cls     = CLS_OP;
            fresh.op_kind = KIND_EQ;
         end
         [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: fresh.cls = CLS_LETTER;
         [CH_DIGIT_0:CH_DIGIT_9]:                           fresh.cls = CLS_DIGIT;
         default:                                           fresh.cls = CLS_OTHER;
      endcase
   end

   // position and line tracking, cleared by end of text
   always_comb begin
      pos_in  = pos_ff;
      line_in = line_ff;
      if (accept) begin
         if (fresh.cls == CLS_END) begin
            pos_in  = '0;
            line_in = LINE_BITS'(1);
         end else begin
            pos_in = pos_next(pos_ff);
            if (fresh.cls == CLS_NEWLINE && line_ff != '1) begin
               line_in = line_ff + LINE_BITS'(1);
            end
         end
      end
   end

   // item queue pointers
   always_comb begin
      wr_ptr_in = accept  ? wr_ptr_ff + ITEM_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = take_ok ? rd_ptr_ff + ITEM_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + ITEM_CNT_BITS'(accept) - ITEM_CNT_BITS'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= fresh;
      end
   end

endmodule

/* src/stt_back.sv */
module stt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  stt_pkg::item_type item,
   output logic              item_take,
   input  logic              room,
   output stt_pkg::emit_type emit
);
   import stt_pkg::*;

   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   start_ff, start_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [PREFIX_BITS-1:0] prefix_ff, prefix_in;
   logic                  go;
   logic                  consumed;
   logic                  mode_hit, disp_hit;
   token_type             mode_tok, disp_tok;
   logic [LEN_BITS-1:0]   len_inc;
   kind_type              word_kind;

   function automatic token_type make_token(input kind_type k,
                                            input logic [OFF_BITS-1:0] off,
                                            input logic [LEN_BITS-1:0] len,
                                            input logic [LINE_BITS-1:0] line);
      token_type t;
      t.kind   = k;
      t.offset = off;
      t.length = len;
      t.line   = line;
      t.last   = 1'b0;
      return t;
   endfunction

   assign go        = item_valid && room;
   assign item_take = go;
   assign len_inc   = (len_ff == '1) ? len_ff : len_ff + LEN_BITS'(1);

   // keyword match on exact length and letters
   always_comb begin
      if (len_ff == KW_PRINTLN_LEN && prefix_ff == KW_PRINTLN) begin
         word_kind = KIND_PRINTLN;
      end else if (len_ff == KW_PRINT_LEN && prefix_ff == KW_PRINT) begin
         word_kind = KIND_PRINT;
      end else if (len_ff == KW_NUM_LEN && prefix_ff == KW_NUM) begin
         word_kind = KIND_NUM_DECL;
      end else if (len_ff == KW_STRING_LEN && prefix_ff == KW_STRING) begin
         word_kind = KIND_STRING_DECL;
      end else if (len_ff == KW_IF_LEN && prefix_ff == KW_IF) begin
         word_kind = KIND_IF;
      end else begin
         word_kind = KIND_ID;
      end
   end

   // scanner step: extend or finish the pending token, then treat an unconsumed byte as fresh
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      prefix_in = prefix_ff;
      consumed  = 1'b0;
      mode_hit  = 1'b0;
      disp_hit  = 1'b0;
      mode_tok  = '0;
      disp_tok  = '0;
      if (go) begin
         case (mode_ff)
            MODE_WORD: begin
               if (item.cls == CLS_LETTER) begin
                  for (int i = 0; i < KW_CHARS; i++) begin
                     if (len_ff == LEN_BITS'(i)) begin
                        prefix_in[CHAR_BITS*i +: CHAR_BITS] = item.ch;
                     end
                  end
                  len_in   = len_inc;
                  consumed = 1'b1;
               end else begin
                  mode_hit = 1'b1;
                  mode_tok = make_token(word_kind, pos_to_offset(start_ff), len_ff, item.line);
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (item.cls == CLS_DIGIT) begin
                  len_in   = len_inc;
                  consumed = 1'b1;
               end else begin
                  mode_hit = 1'b1;
                  mode_tok = make_token(KIND_NUMBER, pos_to_offset(start_ff), len_ff,
                                        item.line);
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_SLASH: begin
               if (item.cls == CLS_SLASH) begin
                  mode_in  = MODE_COMMENT;
                  consumed = 1'b1;
               end else begin
                  mode_hit = 1'b1;
                  mode_tok = make_token(KIND_DIV, pos_to_offset(start_ff), LEN_BITS'(1),
                                        item.line);
                  mode_in  = MODE_IDLE;
               end
            end
            MODE_COMMENT: begin
               if (item.cls == CLS_NEWLINE || item.cls == CLS_END) begin
                  mode_in = MODE_IDLE;
               end else begin
                  consumed = 1'b1;
               end
            end
            MODE_STRING: begin
               if (item.cls == CLS_QUOTE) begin
                  mode_hit = 1'b1;
                  mode_tok = make_token(KIND_STRING, pos_to_offset(start_ff), len_ff,
                                        item.line);
                  mode_in  = MODE_IDLE;
                  consumed = 1'b1;
               end else if (item.cls == CLS_END) begin
                  mode_hit = 1'b1;
                  mode_tok = make_token(KIND_ERROR, pos_to_offset(start_ff), len_ff,
                                        item.line);
                  mode_in  = MODE_IDLE;
               end else begin
                  len_in   = len_inc;
                  consumed = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         if (!consumed) begin
            case (item.cls)
               CLS_OP: begin
                  disp_hit = 1'b1;
                  disp_tok = make_token(item.op_kind, pos_to_offset(item.pos), LEN_BITS'(1),
                                        item.line);
               end
               CLS_SLASH: begin
                  mode_in  = MODE_SLASH;
                  start_in = item.pos;
               end
               CLS_QUOTE: begin
                  mode_in  = MODE_STRING;
                  start_in = pos_next(item.pos);
                  len_in   = '0;
               end
               CLS_END: begin
                  disp_hit = 1'b1;
                  disp_tok = make_token(KIND_EOF, pos_to_offset(item.pos), '0, item.line);
                  mode_in  = MODE_IDLE;
                  len_in   = '0;
               end
               CLS_LETTER: begin
                  mode_in   = MODE_WORD;
                  start_in  = item.pos;
                  len_in    = LEN_BITS'(1);
                  prefix_in = PREFIX_BITS'(item.ch);
               end
               CLS_DIGIT: begin
                  mode_in  = MODE_NUMBER;
                  start_in = item.pos;
                  len_in   = LEN_BITS'(1);
               end
               CLS_OTHER: begin
                  disp_hit = 1'b1;
                  disp_tok = make_token(KIND_ERROR, pos_to_offset(item.pos), LEN_BITS'(1),
                                        item.line);
               end
               default: begin
               end
            endcase
         end
      end
   end

   // order the tokens and flag the final one
   always_comb begin
      emit = '0;
      if (mode_hit && disp_hit) begin
         emit.count       = 2'd2;
         emit.first       = mode_tok;
         emit.second      = disp_tok;
         emit.second.last = 1'b1;
      end else if (mode_hit) begin
         emit.count      = 2'd1;
         emit.first      = mode_tok;
         emit.first.last = 1'b1;
      end else if (disp_hit) begin
         emit.count      = 2'd1;
         emit.first      = disp_tok;
         emit.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   // token start and word letters need no reset
   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      prefix_ff <= prefix_in;
   end

endmodule

/* src/stt_out_queue.sv */
module stt_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::emit_type  emit,
   output logic               room,
   input  logic               pop,
   output logic               empty,
   output stt_pkg::token_type head
);
   import stt_pkg::*;

   token_type               q_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_BITS-1:0] count_ff, count_in;
   logic [OUT_PTR_BITS-1:0] wr_second;
   logic                    pop_ok;

   // room for a full two-token burst
   assign room      = (count_ff <= OUT_CNT_BITS'(OUT_DEPTH - 2));
   assign empty     = (count_ff == '0);
   assign head      = q_ff[rd_ptr_ff];
   assign pop_ok    = pop && !empty;
   assign wr_second = wr_ptr_ff + OUT_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUT_PTR_BITS'(emit.count);
      rd_ptr_in = pop_ok ? rd_ptr_ff + OUT_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + OUT_CNT_BITS'(emit.count) - OUT_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token storage, two write slots
   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= emit.first;
      end
      if (emit.count == 2'd2) begin
         q_ff[wr_second] <= emit.second;
      end
   end

endmodule

/* src/source_text_tokenizer.sv */
// Source text tokenizer.
// Input: one source byte per beat on req_char_in, taken when push is high and
// full is low. A zero byte ends the text and yields an eof token; position and
// line then restart for the next text.
// Output: tokens wait in a queue; the oldest is on the rsp_ ports while empty
// is low and leaves when pop is high. A byte gives zero, one or two tokens;
// rsp_last_of_run marks the final token of a byte.
// Throughput: one byte per cycle while the receiver keeps up. The back end takes a
// queued byte only while the token queue has two free entries, so the second
// token of a byte that gives two tokens is absorbed by that queue.
// With both queues empty, a token is on the rsp_ ports from the edge after the
// one that took the byte that completes it.
// When the receiver stalls, the token queue fills, the back end holds, the
// two-entry byte queue fills and full rises; nothing is dropped.
// Reset: synchronous; both queues empty, scanner idle, position 0, line 1.
module source_text_tokenizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [stt_pkg::CHAR_BITS-1:0]   req_char_in,
   input  logic                            push,
   output logic                            full,
   output logic [stt_pkg::KIND_BITS-1:0]   rsp_token_kind,
   output logic [stt_pkg::OFF_BITS-1:0]    rsp_token_offset,
   output logic [stt_pkg::LEN_BITS-1:0]    rsp_token_length,
   output logic [stt_pkg::LINE_BITS-1:0]   rsp_line_number,
   output logic                            rsp_last_of_run,
   output logic                            empty,
   input  logic                            pop
);
   import stt_pkg::*;

   logic      item_valid;
   item_type  item;
   logic      item_take;
   logic      room;
   emit_type  emit;
   token_type head;

   // byte classification and position tracking
   stt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_char_in (req_char_in),
      .push        (push),
      .full        (full),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take)
   );

   // scanner state machine
   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .room       (room),
      .emit       (emit)
   );

   // token queue
   stt_out_queue u_out_queue (
      .clock (clock),
      .reset (reset),
      .emit  (emit),
      .room  (room),
      .pop   (pop),
      .empty (empty),
      .head  (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_offset = head.offset;
   assign rsp_token_length = head.length;
   assign rsp_line_number  = head.line;
   assign rsp_last_of_run  = head.last;

endmodule

/* src/stt_checker.sv */
`include "source_text_tokenizer_defines.svh"

module stt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [stt_pkg::CHAR_BITS-1:0]   req_char_in,
   input logic                            push,
   input logic                            full,
   input logic [stt_pkg::KIND_BITS-1:0]   rsp_token_kind,
   input logic [stt_pkg::OFF_BITS-1:0]    rsp_token_offset,
   input logic [stt_pkg::LEN_BITS-1:0]    rsp_token_length,
   input logic [stt_pkg::LINE_BITS-1:0]   rsp_line_number,
   input logic                            rsp_last_of_run,
   input logic                            empty,
   input logic                            pop
);
   import stt_pkg::*;

   logic eof_shown;
   logic op_shown;
   logic unused_char;

   assign eof_shown   = !empty && (rsp_token_kind == KIND_BITS'(KIND_EOF));
   assign op_shown    = !empty && (rsp_token_kind <= KIND_BITS'(KIND_DIV));
   assign unused_char = push && (req_char_in == CH_NUL);

   // reset leaves both sides ready and empty
   `STT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (empty && !full), "queues not clear after reset")

   // a waiting token holds until taken
   `STT_ASSERT(a_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_token_kind) && $stable(rsp_token_offset) && $stable(rsp_token_length) && $stable(rsp_line_number) && $stable(rsp_last_of_run)), "waiting token changed")

   // eof closes its run with no text
   `STT_ASSERT(a_eof_shape, clock, reset, eof_shown |-> (rsp_token_length == '0 && rsp_last_of_run), "bad eof token")

   // operator tokens are one byte long
   `STT_ASSERT(a_op_length, clock, reset, op_shown |-> (rsp_token_length == LEN_BITS'(1)), "operator token length not one")

   // lines count from one
   `STT_ASSERT(a_line_nonzero, clock, reset, (!empty || unused_char) |-> (empty || rsp_line_number != '0), "line number zero")

endmodule

bind source_text_tokenizer stt_checker u_checker (.*);
